>>> src/psseq_pkg.sv
// ---------------------------------------------------------------------------
// psseq_pkg
// Shared types, codes and constants of the SoC power-state sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package psseq_pkg;

  // field widths
  localparam int MSG_W      = 2;
  localparam int PCT_W      = 7;
  localparam int UW_W       = 27;
  localparam int STATE_W    = 5;
  localparam int PEND_W     = 3;
  localparam int EVENT_W    = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_SHUTDOWN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTRICTED_UW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_UW       = 2'd2;

  // configuration reset values
  localparam logic [PCT_W-1:0] BATT_SHUTDOWN_RST = 7'd3;
  localparam logic [UW_W-1:0]  RESTRICTED_UW_RST = 27'd1000000;
  localparam logic [UW_W-1:0]  FULL_UW_RST       = 27'd3500000;

  // power states, numbered densely
  typedef enum logic [STATE_W-1:0] {
    ST_G3,
    ST_G3S5_STOD,
    ST_G3S5,
    ST_S5_RS0,
    ST_S5_STODS0,
    ST_S5_SOS5_SOF,
    ST_S5_SOFS5_SO,
    ST_S5_SOFS5_APR,
    ST_S5_APRS5_SOF,
    ST_S5_APRS5_R,
    ST_S5_STODG3,
    ST_S5_SOFG3,
    ST_S5_RG3,
    ST_S5G3,
    ST_S5,
    ST_S5_R,
    ST_S5_STOD,
    ST_S5_APR,
    ST_S5_SOF,
    ST_S5_SO,
    ST_S3,
    ST_S0,
    ST_S0S5_SOF,
    ST_S3S5_SOF,
    ST_S3S5,
    ST_S5S3,
    ST_S3S0,
    ST_S0S3
  } pwr_state_t;

  // host message codes on the input
  typedef enum logic [MSG_W-1:0] {
    MSG_NONE,
    MSG_ENTER_S0,
    MSG_ENTER_S3,
    MSG_ENTER_S5
  } host_msg_t;

  // one-hot pending message
  localparam logic [PEND_W-1:0] PEND_NONE = 3'b000;
  localparam logic [PEND_W-1:0] PEND_S0   = 3'b001;
  localparam logic [PEND_W-1:0] PEND_S3   = 3'b010;
  localparam logic [PEND_W-1:0] PEND_S5   = 3'b100;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE,
    EV_STARTUP,
    EV_SHUTDOWN,
    EV_RESUME,
    EV_SUSPEND
  } notify_t;

  typedef enum logic [STATUS_W-1:0] {
    PS_INSUFFICIENT,
    PS_RESTRICTED,
    PS_FULL
  } pwr_status_t;

  typedef struct packed {
    pwr_state_t        state;
    logic [PEND_W-1:0] pending;
    logic              reset_line;
    logic              isolation;
    logic              bist_done;
  } seq_state_t;

  typedef struct packed {
    logic [PCT_W-1:0] batt_shutdown;
    logic [UW_W-1:0]  restricted_uw;
    logic [UW_W-1:0]  full_uw;
  } seq_cfg_t;

  typedef struct packed {
    logic [MSG_W-1:0] new_message;
    logic             button_pressed;
    logic [PCT_W-1:0] battery_percent;
    logic             external_power;
    logic [UW_W-1:0]  charger_power_uw;
  } in_item_t;

  typedef struct packed {
    logic [STATE_W-1:0]  next_state;
    logic                ap_in_reset;
    logic                ap_isolate_reg;
    logic                bist_released;
    logic [EVENT_W-1:0]  notify_event;
    logic                status_valid;
    logic [STATUS_W-1:0] boot_power;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/psseq_in_if.sv
// ---------------------------------------------------------------------------
// psseq_in_if
// Input channel: host message and sampled button, battery and charger inputs.
// ---------------------------------------------------------------------------
`default_nettype none

interface psseq_in_if
  import psseq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [MSG_W-1:0] new_message;
  logic             button_pressed;
  logic [PCT_W-1:0] battery_percent;
  logic             external_power;
  logic [UW_W-1:0]  charger_power_uw;

  modport source (
    output valid, new_message, button_pressed, battery_percent,
           external_power, charger_power_uw,
    input  ready
  );

  modport sink (
    input  valid, new_message, button_pressed, battery_percent,
           external_power, charger_power_uw,
    output ready
  );
endinterface

`default_nettype wire

>>> src/psseq_out_if.sv
// ---------------------------------------------------------------------------
// psseq_out_if
// Result channel: power state, control levels, notification and status.
// ---------------------------------------------------------------------------
`default_nettype none

interface psseq_out_if
  import psseq_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATE_W-1:0]  next_state;
  logic                ap_in_reset;
  logic                ap_isolate_reg;
  logic                bist_released;
  logic [EVENT_W-1:0]  notify_event;
  logic                status_valid;
  logic [STATUS_W-1:0] boot_power;

  modport source (
    output valid, next_state, ap_in_reset, ap_isolate_reg, bist_released,
           notify_event, status_valid, boot_power,
    input  ready
  );

  modport sink (
    input  valid, next_state, ap_in_reset, ap_isolate_reg, bist_released,
           notify_event, status_valid, boot_power,
    output ready
  );
endinterface

`default_nettype wire

>>> src/psseq_step.sv
// ---------------------------------------------------------------------------
// psseq_step
// One step of the power machine: message latch, next state, control updates,
// lifecycle notification and boot-power classification.
// ---------------------------------------------------------------------------
`default_nettype none

module psseq_step
  import psseq_pkg::*;
(
  input  seq_state_t cur,
  input  in_item_t   item,
  input  seq_cfg_t   cfg,
  output seq_state_t nxt,
  output out_item_t  res
);

  logic [PEND_W-1:0] pend_in;
  pwr_status_t       cls;
  notify_t           ev;
  logic              sv;
  pwr_state_t        state_next;
  logic [PEND_W-1:0] pending_next;
  logic              reset_line_next;
  logic              isolation_next;
  logic              bist_done_next;

  // latch a new host message, replacing any pending one
  always_comb begin
    case (host_msg_t'(item.new_message))
      MSG_ENTER_S0: pend_in = PEND_S0;
      MSG_ENTER_S3: pend_in = PEND_S3;
      MSG_ENTER_S5: pend_in = PEND_S5;
      default:      pend_in = cur.pending;
    endcase
  end

  // boot-power classification, compares in priority order
  always_comb begin
    if (item.battery_percent > cfg.batt_shutdown) begin
      cls = PS_FULL;
    end else if (!item.external_power) begin
      cls = PS_INSUFFICIENT;
    end else if (item.charger_power_uw < cfg.restricted_uw) begin
      cls = PS_INSUFFICIENT;
    end else if (item.charger_power_uw < cfg.full_uw) begin
      cls = PS_RESTRICTED;
    end else begin
      cls = PS_FULL;
    end
  end

  // next state and message consumption
  always_comb begin
    state_next   = cur.state;
    pending_next = pend_in;
    unique case (cur.state)
      ST_G3:                          state_next = ST_G3S5_STOD;
      ST_G3S5_STOD, ST_G3S5:          state_next = ST_S5_STOD;
      ST_S5_RS0, ST_S5_STODS0:        state_next = ST_S0;
      ST_S5_SOS5_SOF:                 state_next = ST_S5_SOF;
      ST_S5_SOFS5_SO:                 state_next = ST_S5_SO;
      ST_S5_SOFS5_APR:                state_next = ST_S5_APR;
      ST_S5_APRS5_SOF:                state_next = ST_S5_SOF;
      ST_S5_APRS5_R:                  state_next = ST_S5_R;
      ST_S5_STODG3, ST_S5_SOFG3,
      ST_S5_RG3, ST_S5G3:             state_next = ST_G3;
      ST_S5, ST_S5_SO:                state_next = cur.state;
      ST_S5_R: begin
        if (pend_in == PEND_S0) begin
          pending_next = PEND_NONE;
          state_next   = ST_S5_RS0;
        end
      end
      ST_S5_STOD: begin
        if (pend_in == PEND_S0) begin
          pending_next = PEND_NONE;
          state_next   = ST_S5_STODS0;
        end
      end
      ST_S5_APR:                      state_next = ST_S5_APRS5_R;
      ST_S5_SOF: begin
        if (item.button_pressed) begin
          state_next = ST_S5_SOFS5_APR;
        end
      end
      ST_S3: begin
        if (pend_in == PEND_S0) begin
          pending_next = PEND_NONE;
          state_next   = ST_S3S0;
        end else if (pend_in == PEND_S5) begin
          pending_next = PEND_NONE;
          state_next   = ST_S3S5_SOF;
        end
      end
      ST_S0: begin
        if (pend_in == PEND_S3) begin
          pending_next = PEND_NONE;
          state_next   = ST_S0S3;
        end else if (pend_in == PEND_S5) begin
          pending_next = PEND_NONE;
          state_next   = ST_S0S5_SOF;
        end
      end
      ST_S0S5_SOF, ST_S3S5_SOF, ST_S3S5: state_next = ST_S5_SOF;
      // entering S3 from S5 behaves as resume to S0
      ST_S5S3, ST_S3S0:               state_next = ST_S0;
      ST_S0S3:                        state_next = ST_S3;
      default:                        state_next = cur.state;
    endcase
  end

  // control lines, notification and status report
  always_comb begin
    reset_line_next = cur.reset_line;
    isolation_next  = cur.isolation;
    bist_done_next  = cur.bist_done;
    ev              = EV_NONE;
    sv              = 1'b0;
    unique case (cur.state)
      ST_G3S5_STOD, ST_G3S5: sv = 1'b1;
      ST_S5_RS0, ST_S5_STODS0: ev = EV_STARTUP;
      ST_S5_SOFS5_APR: reset_line_next = 1'b1;
      ST_S5_APRS5_SOF: begin
        reset_line_next = 1'b0;
        bist_done_next  = 1'b1;
      end
      ST_S5_APRS5_R: begin
        sv              = 1'b1;
        isolation_next  = 1'b1;
        reset_line_next = 1'b0;
        bist_done_next  = 1'b1;
      end
      ST_S0S5_SOF, ST_S3S5_SOF, ST_S3S5: begin
        ev              = EV_SHUTDOWN;
        reset_line_next = 1'b1;
        isolation_next  = 1'b0;
      end
      ST_S5S3, ST_S3S0: ev = EV_RESUME;
      ST_S0S3:          ev = EV_SUSPEND;
      default: ;
    endcase
  end

  // updated machine state and result item
  always_comb begin
    nxt.state          = state_next;
    nxt.pending        = pending_next;
    nxt.reset_line     = reset_line_next;
    nxt.isolation      = isolation_next;
    nxt.bist_done      = bist_done_next;
    res.next_state     = state_next;
    res.ap_in_reset    = reset_line_next;
    res.ap_isolate_reg = isolation_next;
    res.bist_released  = bist_done_next;
    res.notify_event   = ev;
    res.status_valid   = sv;
    res.boot_power     = sv ? cls : PS_INSUFFICIENT;
  end

endmodule

`default_nettype wire

>>> src/soc_power_state_sequencer.sv
// ---------------------------------------------------------------------------
// soc_power_state_sequencer
// Power sequencer for a system-on-chip: one power-machine step per item.
// ---------------------------------------------------------------------------
// Usage:
//   item   - valid/ready input channel; each transfer carries an optional
//            host message plus sampled button, battery and charger inputs.
//   result - valid/ready output channel; one result per input transfer,
//            in order: next power state, AP reset, isolation, BIST release,
//            notification and the classified boot-power status.
//   cfg_*  - write port for the battery and charger thresholds; write only
//            while no item is in flight.
// An item waits in the input register, then one step of the state machine
// moves it into the result register, where the result stays until it is
// taken. One item per cycle is sustained while the receiver keeps
// result.ready high; the step logic is a small state decode plus a few
// threshold compares.
// Reset puts the machine in the G3-to-S5 start-of-day state with no pending
// message, the AP reset, AP isolation and BIST release all low, and loads
// the default thresholds. When the receiver stalls, the result register
// holds, the input register fills, and item.ready drops after that.
// ---------------------------------------------------------------------------
`default_nettype none

module soc_power_state_sequencer
  import psseq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  psseq_in_if.sink                   item,
  psseq_out_if.source                result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  seq_cfg_t   cfg;
  seq_state_t st;
  seq_state_t st_next;
  logic       s1_valid;
  in_item_t   s1_item;
  logic       res_valid;
  out_item_t  res_item;
  out_item_t  res_next;
  logic       advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batt_shutdown <= BATT_SHUTDOWN_RST;
      cfg.restricted_uw <= RESTRICTED_UW_RST;
      cfg.full_uw       <= FULL_UW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BATT_SHUTDOWN: cfg.batt_shutdown <= cfg_data[PCT_W-1:0];
        CFG_RESTRICTED_UW: cfg.restricted_uw <= cfg_data[UW_W-1:0];
        CFG_FULL_UW:       cfg.full_uw       <= cfg_data[UW_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the result register frees up when empty or taken
  assign advance    = !res_valid || result.ready;
  assign item.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_item.new_message      <= item.new_message;
      s1_item.button_pressed   <= item.button_pressed;
      s1_item.battery_percent  <= item.battery_percent;
      s1_item.external_power   <= item.external_power;
      s1_item.charger_power_uw <= item.charger_power_uw;
    end
  end

  // one step of the power machine
  psseq_step u_step (
    .cur  (st),
    .item (s1_item),
    .cfg  (cfg),
    .nxt  (st_next),
    .res  (res_next)
  );

  // machine state advances when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.state      <= ST_G3S5_STOD;
      st.pending    <= PEND_NONE;
      st.reset_line <= 1'b0;
      st.isolation  <= 1'b0;
      st.bist_done  <= 1'b0;
    end else if (advance && s1_valid) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_item <= res_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.next_state     = res_item.next_state;
  assign result.ap_in_reset    = res_item.ap_in_reset;
  assign result.ap_isolate_reg = res_item.ap_isolate_reg;
  assign result.bist_released  = res_item.bist_released;
  assign result.notify_event   = res_item.notify_event;
  assign result.status_valid   = res_item.status_valid;
  assign result.boot_power     = res_item.boot_power;

endmodule

`default_nettype wire

>>> bench/tb_soc_power_state_sequencer.sv
// ---------------------------------------------------------------------------
// tb_soc_power_state_sequencer
// Self-checking bench for the SoC power-state sequencer. A directed walk
// through the power cycles is followed by random host messages, buttons,
// battery and charger readings under several threshold settings. Every
// result transfer is compared with a cycle-free model of the power machine,
// while both channels idle and stall at random outside the one steady phase.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_soc_power_state_sequencer;
  import psseq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PCT_MAX     = 100;
  localparam int UW_MAX      = 100_000_000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 254;
  localparam int DRAIN_LIMIT = 50_000;

  // write to an index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  psseq_in_if  item_if ();
  psseq_out_if result_if ();

  soc_power_state_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_if),
    .result    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // model of the power machine and its thresholds
  pwr_state_t        mdl_state    = ST_G3S5_STOD;
  logic [PEND_W-1:0] mdl_pend     = PEND_NONE;
  logic              mdl_rst_line = 1'b0;
  logic              mdl_iso      = 1'b0;
  logic              mdl_bist     = 1'b0;
  seq_cfg_t          mdl_cfg      = '{BATT_SHUTDOWN_RST, RESTRICTED_UW_RST, FULL_UW_RST};

  in_item_t  item_backlog[$];
  out_item_t step_results_due[$];

  bit          steady           = 1'b0;
  int          mismatches       = 0;
  int          run_errors       = 0;
  int          items_taken      = 0;
  int          results_checked  = 0;
  int          settings_applied = 0;
  int          status_seen[3]   = '{0, 0, 0};
  logic [31:0] states_seen      = '0;

  // boot-power grading, compares in the order the hardware makes them
  function automatic pwr_status_t grade_power(input in_item_t it);
    if (it.battery_percent > mdl_cfg.batt_shutdown) return PS_FULL;
    if (!it.external_power) return PS_INSUFFICIENT;
    if (it.charger_power_uw < mdl_cfg.restricted_uw) return PS_INSUFFICIENT;
    if (it.charger_power_uw < mdl_cfg.full_uw) return PS_RESTRICTED;
    return PS_FULL;
  endfunction

  // one step of the power machine; updates the model state
  function automatic out_item_t advance_power_machine(input in_item_t it);
    out_item_t   res;
    pwr_state_t  nx;
    notify_t     ev;
    logic        report;
    pwr_status_t grade;
    nx     = mdl_state;
    ev     = EV_NONE;
    report = 1'b0;
    grade  = PS_INSUFFICIENT;

    // a new message replaces whatever is pending
    case (host_msg_t'(it.new_message))
      MSG_ENTER_S0: mdl_pend = PEND_S0;
      MSG_ENTER_S3: mdl_pend = PEND_S3;
      MSG_ENTER_S5: mdl_pend = PEND_S5;
      default: ;
    endcase

    case (mdl_state)
      ST_G3: nx = ST_G3S5_STOD;
      ST_G3S5_STOD, ST_G3S5: begin
        report = 1'b1;
        grade  = grade_power(it);
        nx     = ST_S5_STOD;
      end
      ST_S5_RS0, ST_S5_STODS0: begin
        ev = EV_STARTUP;
        nx = ST_S0;
      end
      ST_S5_SOS5_SOF: nx = ST_S5_SOF;
      ST_S5_SOFS5_SO: nx = ST_S5_SO;
      ST_S5_SOFS5_APR: begin
        mdl_rst_line = 1'b1;
        nx           = ST_S5_APR;
      end
      ST_S5_APRS5_SOF: begin
        mdl_bist     = 1'b1;
        mdl_rst_line = 1'b0;
        nx           = ST_S5_SOF;
      end
      ST_S5_APRS5_R: begin
        report       = 1'b1;
        grade        = grade_power(it);
        mdl_iso      = 1'b1;
        mdl_bist     = 1'b1;
        mdl_rst_line = 1'b0;
        nx           = ST_S5_R;
      end
      ST_S5_STODG3, ST_S5_SOFG3, ST_S5_RG3, ST_S5G3: nx = ST_G3;
      ST_S5_R: begin
        if (mdl_pend == PEND_S0) begin
          mdl_pend = PEND_NONE;
          nx       = ST_S5_RS0;
        end
      end
      ST_S5_STOD: begin
        if (mdl_pend == PEND_S0) begin
          mdl_pend = PEND_NONE;
          nx       = ST_S5_STODS0;
        end
      end
      ST_S5_APR: nx = ST_S5_APRS5_R;
      ST_S5_SOF: begin
        if (it.button_pressed) nx = ST_S5_SOFS5_APR;
      end
      ST_S3: begin
        if (mdl_pend == PEND_S0) begin
          mdl_pend = PEND_NONE;
          nx       = ST_S3S0;
        end else if (mdl_pend == PEND_S5) begin
          mdl_pend = PEND_NONE;
          nx       = ST_S3S5_SOF;
        end
      end
      ST_S0: begin
        if (mdl_pend == PEND_S3) begin
          mdl_pend = PEND_NONE;
          nx       = ST_S0S3;
        end else if (mdl_pend == PEND_S5) begin
          mdl_pend = PEND_NONE;
          nx       = ST_S0S5_SOF;
        end
      end
      ST_S0S5_SOF, ST_S3S5_SOF, ST_S3S5: begin
        ev           = EV_SHUTDOWN;
        mdl_rst_line = 1'b1;
        mdl_iso      = 1'b0;
        nx           = ST_S5_SOF;
      end
      // the S5-to-S3 step runs on into the S3-to-S0 step
      ST_S5S3, ST_S3S0: begin
        ev = EV_RESUME;
        nx = ST_S0;
      end
      ST_S0S3: begin
        ev = EV_SUSPEND;
        nx = ST_S3;
      end
      // S5, S5 soft-off hold and anything unknown stay put
      default: ;
    endcase

    mdl_state          = nx;
    res.next_state     = nx;
    res.ap_in_reset    = mdl_rst_line;
    res.ap_isolate_reg = mdl_iso;
    res.bist_released  = mdl_bist;
    res.notify_event   = ev;
    res.status_valid   = report;
    res.boot_power     = grade;
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // value near a threshold, clipped to the field range
  function automatic int near(input int center, input int span, input int top);
    int v;
    v = center + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.new_message    = ($urandom_range(0, 2) == 0) ? MSG_W'($urandom_range(1, 3))
                                                    : MSG_NONE;
    it.button_pressed = 1'($urandom_range(0, 1));
    it.external_power = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 2);
    if (pick == 0) it.battery_percent = PCT_W'(near(int'(mdl_cfg.batt_shutdown), 2, PCT_MAX));
    else           it.battery_percent = PCT_W'($urandom_range(0, PCT_MAX));
    pick = $urandom_range(0, 7);
    case (pick)
      0, 1:    it.charger_power_uw = UW_W'(near(int'(mdl_cfg.restricted_uw), 2, UW_MAX));
      2, 3:    it.charger_power_uw = UW_W'(near(int'(mdl_cfg.full_uw), 2, UW_MAX));
      4:       it.charger_power_uw = $urandom_range(0, 1) ? UW_W'(UW_MAX) : '0;
      default: it.charger_power_uw = UW_W'($urandom_range(0, UW_MAX));
    endcase
    return it;
  endfunction

  task automatic queue_item(input host_msg_t msg, input logic btn, input int batt,
                            input logic ext, input int chg);
    in_item_t it;
    it.new_message      = msg;
    it.button_pressed   = btn;
    it.battery_percent  = PCT_W'(batt);
    it.external_power   = ext;
    it.charger_power_uw = UW_W'(chg);
    item_backlog.push_back(it);
  endtask

  // register write; the caller lowers the write enable afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_BATT_SHUTDOWN: mdl_cfg.batt_shutdown = val[PCT_W-1:0];
      CFG_RESTRICTED_UW: mdl_cfg.restricted_uw = val[UW_W-1:0];
      CFG_FULL_UW:       mdl_cfg.full_uw       = val[UW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [CFG_DATA_W-1:0] batt,
                                input logic [CFG_DATA_W-1:0] restricted,
                                input logic [CFG_DATA_W-1:0] full);
    write_reg(CFG_BATT_SHUTDOWN, batt);
    write_reg(CFG_RESTRICTED_UW, restricted);
    write_reg(CFG_FULL_UW, full);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // wait until every queued item has moved through and been checked
  task automatic drain();
    int waited;
    waited = 0;
    while (!(item_backlog.size() == 0 && !item_if.valid && step_results_due.size() == 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      $error("sequencer stuck: %0d items queued, %0d results outstanding",
             item_backlog.size(), step_results_due.size());
      run_errors++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // driver: next item from the backlog once the current one is taken
  int send_gap;
  always @(posedge clk) begin
    in_item_t nxt;
    if (rst) begin
      item_if.valid <= 1'b0;
      send_gap = 0;
    end else if (!item_if.valid || item_if.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        item_if.valid <= 1'b0;
      end else if (item_backlog.size() > 0) begin
        nxt = item_backlog.pop_front();
        item_if.new_message      <= nxt.new_message;
        item_if.button_pressed   <= nxt.button_pressed;
        item_if.battery_percent  <= nxt.battery_percent;
        item_if.external_power   <= nxt.external_power;
        item_if.charger_power_uw <= nxt.charger_power_uw;
        item_if.valid            <= 1'b1;
        send_gap = steady ? 0 : pick_gap();
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // predict on every input transfer
  always @(posedge clk) begin
    in_item_t it;
    if (!rst && item_if.valid && item_if.ready) begin
      it.new_message      = item_if.new_message;
      it.button_pressed   = item_if.button_pressed;
      it.battery_percent  = item_if.battery_percent;
      it.external_power   = item_if.external_power;
      it.charger_power_uw = item_if.charger_power_uw;
      step_results_due.push_back(advance_power_machine(it));
      items_taken++;
    end
  end

  // receiver back-pressure
  int stall_left;
  always @(posedge clk) begin
    int g;
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else begin
      g = steady ? 0 : pick_gap();
      if (g == 0) begin
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= 1'b0;
        stall_left = g - 1;
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (step_results_due.size() == 0) begin
        $error("result transfer with no step outstanding, next_state %0d",
               result_if.next_state);
        mismatches++;
      end else begin
        want = step_results_due.pop_front();
        check_field("next_state", 32'(want.next_state), 32'(result_if.next_state));
        check_field("ap_in_reset", 32'(want.ap_in_reset), 32'(result_if.ap_in_reset));
        check_field("ap_isolate_reg", 32'(want.ap_isolate_reg),
                    32'(result_if.ap_isolate_reg));
        check_field("bist_released", 32'(want.bist_released),
                    32'(result_if.bist_released));
        check_field("notify_event", 32'(want.notify_event), 32'(result_if.notify_event));
        check_field("status_valid", 32'(want.status_valid), 32'(result_if.status_valid));
        check_field("boot_power", 32'(want.boot_power), 32'(result_if.boot_power));
        results_checked++;
        states_seen[want.next_state] = 1'b1;
        if (want.status_valid) status_seen[want.boot_power]++;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [CFG_DATA_W-1:0] r;
    cfg_we    = 1'b0;
    cfg_index = CFG_BATT_SHUTDOWN;
    cfg_data  = '0;

    // directed walk at the reset thresholds
    queue_item(MSG_NONE, 1'b0, PCT_MAX, 1'b1, UW_MAX);   // start of day, full power
    queue_item(MSG_ENTER_S3, 1'b0, 0, 1'b0, 0);          // not expected, stays pending
    queue_item(MSG_ENTER_S0, 1'b0, 0, 1'b0, 0);          // replaces it, boot
    queue_item(MSG_ENTER_S5, 1'b0, 0, 1'b0, 0);          // lands mid-transition
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);              // S0 takes the S5 request
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);              // shutdown
    queue_item(MSG_NONE, 1'b1, 0, 1'b0, 0);              // power button
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, UW_MAX);         // no charger: insufficient
    queue_item(MSG_ENTER_S0, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);              // startup
    queue_item(MSG_ENTER_S3, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);              // suspend
    queue_item(MSG_ENTER_S0, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);              // resume
    queue_item(MSG_ENTER_S3, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_ENTER_S5, 1'b0, 0, 1'b0, 0);          // shutdown from S3
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b1, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b0, 0, 1'b0, 0);
    queue_item(MSG_NONE, 1'b0, 3, 1'b1, 1_000_000);      // charger at the restricted mark

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // random phases, thresholds changed only while drained
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      steady = 1'b0;
      case (ph)
        0: set_thresholds(20, 2_000_000, 5_000_000);
        1: set_thresholds(0, 0, 0);
        2: set_thresholds(CFG_DATA_W'(PCT_MAX), CFG_DATA_W'(UW_MAX), CFG_DATA_W'(UW_MAX));
        3: begin
          // unmapped index, a wide battery value, restricted above full
          write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
          set_thresholds({20'hFFFFF, 7'd50}, 60_000_000, 10_000_000);
          steady = 1'b1;
        end
        4: begin
          r = CFG_DATA_W'($urandom_range(0, UW_MAX));
          set_thresholds(CFG_DATA_W'($urandom_range(0, PCT_MAX)), r,
                         CFG_DATA_W'($urandom_range(32'(r), UW_MAX)));
        end
        default: set_thresholds(CFG_DATA_W'(BATT_SHUTDOWN_RST), RESTRICTED_UW_RST,
                                FULL_UW_RST);
      endcase
      @(negedge clk);
      repeat (PHASE_ITEMS) item_backlog.push_back(random_item());
    end

    drain();
    repeat (8) @(posedge clk);
    if (step_results_due.size() != 0) begin
      $error("%0d expected results never arrived", step_results_due.size());
      run_errors++;
    end

    $display("run: %0d steps checked over %0d threshold settings, %0d power states reached",
             results_checked, settings_applied, $countones(states_seen));
    $display("boot-power reports: %0d insufficient, %0d restricted, %0d full",
             status_seen[PS_INSUFFICIENT], status_seen[PS_RESTRICTED], status_seen[PS_FULL]);
    if (mismatches == 0 && run_errors == 0) begin
      $display("soc_power_state_sequencer regression: pass");
    end else begin
      $display("soc_power_state_sequencer regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("soc_power_state_sequencer regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/psseq_pkg.sv
src/psseq_in_if.sv
src/psseq_out_if.sv
src/psseq_step.sv
src/soc_power_state_sequencer.sv
bench/tb_soc_power_state_sequencer.sv
